// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the datapath rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// expression must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== hw/rtl/atbt_pkg.sv =====
// types, constants and codes of the array binary tree engine
package atbt_pkg;

    // store geometry
    localparam int NODES       = 63;
    localparam int LEVELS      = 6;
    localparam int VALUE_BITS  = 16;
    localparam int STACK_DEPTH = 6;

    localparam int IDX_W  = $clog2(NODES);
    localparam int TGT_W  = IDX_W + 1;
    localparam int SCAN_W = $clog2(NODES + 1);
    localparam int D_W    = $clog2(STACK_DEPTH + 1);
    localparam int SI_W   = $clog2(STACK_DEPTH);

    // port field widths
    localparam int REQ_W = 4;
    localparam int LVL_W = 3;
    localparam int ORD_W = 6;
    localparam int VAL_W = 16;
    localparam int ST_W  = 2;
    localparam int DEP_W = 3;

    localparam logic [VAL_W-1:0] VAL_MASK = (VALUE_BITS >= VAL_W) ? {VAL_W{1'b1}} :
        VAL_W'((32'd1 << VALUE_BITS) - 32'd1);

    // request codes
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 4'd0;
    localparam logic [REQ_W-1:0] REQ_ASSIGN = 4'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 4'd2;
    localparam logic [REQ_W-1:0] REQ_PARENT = 4'd3;
    localparam logic [REQ_W-1:0] REQ_LCHILD = 4'd4;
    localparam logic [REQ_W-1:0] REQ_RCHILD = 4'd5;
    localparam logic [REQ_W-1:0] REQ_LSIB   = 4'd6;
    localparam logic [REQ_W-1:0] REQ_RSIB   = 4'd7;
    localparam logic [REQ_W-1:0] REQ_DEPTH  = 4'd8;
    localparam logic [REQ_W-1:0] REQ_PRE    = 4'd9;
    localparam logic [REQ_W-1:0] REQ_IN     = 4'd10;
    localparam logic [REQ_W-1:0] REQ_POST   = 4'd11;

    // status codes
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_REFUSED = 2'd1;
    localparam logic [ST_W-1:0] ST_BADPOS  = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY   = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_RD, S_RES, S_DIRECT, S_SCAN, S_WSTEP, S_WDATA, S_WEND
    } t_state;

    typedef enum logic [1:0] {OUT_NONE, OUT_DIRECT, OUT_RES, OUT_LAST} t_out_sel;

    typedef struct packed {
        logic     latch;
        logic     clear;
        logic     assign_wr;
        logic     rd_start;
        logic     scan_init;
        logic     scan_step;
        logic     scan_hit;
        logic     scan_miss;
        logic     walk_init;
        logic     walk_rd;
        logic     walk_take;
        logic     walk_adv;
        t_out_sel out_sel;
    } t_cmd;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             pos_ok;
        logic             root_occ;
        logic             match;
        logic             scan_done;
        logic             emit_now;
        logic             emitted;
        logic             walk_end;
        logic             pend_has;
        logic             out_free;
    } t_sts;

endpackage

// ===== hw/rtl/atbt_ram.sv =====
// generic single write port ram with registered read
module atbt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds when idle
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/atbt_ctrl.sv =====
// request sequencer of the array binary tree engine
module atbt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  atbt_pkg::t_sts i_sts,
    output atbt_pkg::t_cmd o_cmd
);
    import atbt_pkg::*;

    t_state r_state, n_state;
    t_cmd   cmd;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        cmd.out_sel = OUT_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.latch = 1'b1;
                    n_state   = S_DEC;
                end
            end
            S_DEC: begin
                case (i_sts.req) inside
                    REQ_CLEAR: begin
                        cmd.clear = 1'b1;
                        n_state   = S_DIRECT;
                    end
                    REQ_ASSIGN: begin
                        if (i_sts.pos_ok) begin
                            cmd.assign_wr = 1'b1;
                            n_state       = S_RD;
                        end else begin
                            n_state = S_DIRECT;
                        end
                    end
                    REQ_READ: begin
                        n_state = i_sts.pos_ok ? S_RD : S_DIRECT;
                    end
                    [REQ_PARENT:REQ_RSIB]: begin
                        if (i_sts.root_occ) begin
                            cmd.scan_init = 1'b1;
                            n_state       = S_SCAN;
                        end else begin
                            n_state = S_DIRECT;
                        end
                    end
                    REQ_DEPTH: begin
                        n_state = i_sts.root_occ ? S_RD : S_DIRECT;
                    end
                    [REQ_PRE:REQ_POST]: begin
                        if (i_sts.root_occ) begin
                            cmd.walk_init = 1'b1;
                            n_state       = S_WSTEP;
                        end else begin
                            n_state = S_DIRECT;
                        end
                    end
                    default: begin
                        n_state = S_DIRECT;
                    end
                endcase
            end
            S_RD: begin
                cmd.rd_start = 1'b1;
                n_state      = S_RES;
            end
            S_RES: begin
                if (i_sts.out_free) begin
                    cmd.out_sel = OUT_RES;
                    n_state     = S_IDLE;
                end
            end
            S_DIRECT: begin
                if (i_sts.out_free) begin
                    cmd.out_sel = OUT_DIRECT;
                    n_state     = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_sts.match) begin
                    cmd.scan_hit = 1'b1;
                    n_state      = S_RD;
                end else if (i_sts.scan_done) begin
                    cmd.scan_miss = 1'b1;
                    n_state       = S_RD;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_WSTEP: begin
                if (i_sts.emit_now && !i_sts.emitted) begin
                    cmd.walk_rd = 1'b1;
                    n_state     = S_WDATA;
                end else if (i_sts.walk_end) begin
                    n_state = S_WEND;
                end else begin
                    cmd.walk_adv = 1'b1;
                end
            end
            S_WDATA: begin
                if (!i_sts.pend_has || i_sts.out_free) begin
                    cmd.walk_take = 1'b1;
                    n_state       = S_WSTEP;
                end
            end
            S_WEND: begin
                if (i_sts.out_free) begin
                    cmd.out_sel = OUT_LAST;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd      = cmd;
    assign o_in_ready = (r_state == S_IDLE);
endmodule

// ===== hw/rtl/atbt_dp.sv =====
// node store, search, walk and output datapath of the tree engine
`include "assert_macros.svh"
module atbt_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [atbt_pkg::REQ_W-1:0]   i_req_type,
    input  logic [atbt_pkg::LVL_W-1:0]   i_node_level,
    input  logic [atbt_pkg::ORD_W-1:0]   i_node_order,
    input  logic [atbt_pkg::VAL_W-1:0]   i_item_value,
    input  atbt_pkg::t_cmd               i_cmd,
    output atbt_pkg::t_sts               o_sts,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [atbt_pkg::VAL_W-1:0]   o_result_value,
    output logic [atbt_pkg::ST_W-1:0]    o_status,
    output logic [atbt_pkg::DEP_W-1:0]   o_tree_depth,
    output logic                         o_last
);
    import atbt_pkg::*;

    // walk phases: arrived from parent, back from left, back from right
    localparam logic [1:0] PH_DOWN  = 2'd0;
    localparam logic [1:0] PH_LEFT  = 2'd1;
    localparam logic [1:0] PH_RIGHT = 2'd2;

    logic [NODES-1:0] r_occ;
    logic [REQ_W-1:0] r_req;
    logic [IDX_W-1:0] r_idx;
    logic             r_pos_ok;
    logic [VAL_W-1:0] r_v;
    logic [ST_W-1:0]  r_st;
    logic [IDX_W-1:0] r_tgt;
    logic             r_tgt_ok;
    logic             r_rd_occ;
    logic [SCAN_W-1:0] r_scan;
    logic             r_chk_v;
    logic [IDX_W-1:0] r_chk_idx;
    logic [IDX_W-1:0] r_cur;
    logic [D_W-1:0]   r_d;
    logic [1:0]       r_phase;
    logic             r_emitted;
    logic [IDX_W-1:0] r_stack [STACK_DEPTH];
    logic [VAL_W-1:0] r_pend_val;
    logic             r_pend_has;
    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_val;
    logic [ST_W-1:0]  r_out_st;
    logic [DEP_W-1:0] r_out_dep;
    logic             r_out_last;

    logic [7:0]       base, pos_sum;
    logic             pos_ok;
    logic [IDX_W-1:0] pos_idx;
    logic [VAL_W-1:0] rdata, eff;
    logic             refuse;
    logic [TGT_W-1:0] parent_t, lch_t, rch_t, hit_t;
    logic [TGT_W-1:0] wl_t, wr_t;
    logic             side_ok, match, can_left, can_right, emit_now;
    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic             rd_occ_n;
    logic [DEP_W-1:0] depth;
    logic             out_free;
    logic [D_W-1:0]   d_dec;

    // occupancy of a slot, empty beyond the store
    function automatic logic occ_at(input logic [NODES-1:0] occ, input logic [TGT_W-1:0] t);
        logic res;
        res = 1'b0;
        if (t < TGT_W'(NODES)) begin
            res = occ[t[IDX_W-1:0]];
        end
        return res;
    endfunction

    // position decode of the incoming item
    always_comb begin
        base    = (i_node_level == '0) ? 8'd0 : (8'd1 << (i_node_level - 3'd1));
        pos_sum = base + 8'(i_node_order) - 8'd2;
        pos_ok  = (i_node_level != '0) && (32'(i_node_level) <= LEVELS) &&
                  (i_node_order != '0) && (8'(i_node_order) <= base) &&
                  (pos_sum < 8'(NODES));
        pos_idx = pos_sum[IDX_W-1:0];
    end

    // levels in use from per-level occupancy
    always_comb begin
        depth = '0;
        for (int lv = 1; lv <= LEVELS; lv++) begin
            for (int j = (1 << (lv - 1)) - 1; j < (1 << lv) - 1; j++) begin
                if (j < NODES && r_occ[j]) begin
                    depth = DEP_W'(lv);
                end
            end
        end
    end

    assign eff = r_rd_occ ? rdata : '0;

    // assign checks
    always_comb begin
        parent_t = (TGT_W'(r_idx) - TGT_W'(1)) >> 1;
        lch_t    = {r_idx, 1'b1};
        rch_t    = {r_idx, 1'b0} + TGT_W'(2);
        refuse   = ((r_v != '0) && (r_idx != '0) && !occ_at(r_occ, parent_t)) ||
                   ((r_v == '0) && (occ_at(r_occ, lch_t) || occ_at(r_occ, rch_t)));
    end

    // search hit and its relative
    always_comb begin
        side_ok = 1'b1;
        hit_t   = '0;
        case (r_req)
            REQ_PARENT: hit_t = (TGT_W'(r_chk_idx) - TGT_W'(1)) >> 1;
            REQ_LCHILD: hit_t = {r_chk_idx, 1'b1};
            REQ_RCHILD: hit_t = {r_chk_idx, 1'b0} + TGT_W'(2);
            REQ_LSIB: begin
                side_ok = !r_chk_idx[0];
                hit_t   = TGT_W'(r_chk_idx) - TGT_W'(1);
            end
            REQ_RSIB: begin
                side_ok = r_chk_idx[0];
                hit_t   = TGT_W'(r_chk_idx) + TGT_W'(1);
            end
            default: side_ok = 1'b0;
        endcase
        match = r_chk_v && side_ok && (eff == r_v);
    end

    // walk neighbors
    always_comb begin
        wl_t      = {r_cur, 1'b1};
        wr_t      = {r_cur, 1'b0} + TGT_W'(2);
        can_left  = occ_at(r_occ, wl_t) && (r_d < D_W'(STACK_DEPTH));
        can_right = occ_at(r_occ, wr_t) && (r_d < D_W'(STACK_DEPTH));
        emit_now  = ((r_phase == PH_DOWN) && (r_req == REQ_PRE)) ||
                    ((r_phase == PH_LEFT) && (r_req == REQ_IN)) ||
                    ((r_phase == PH_RIGHT) && (r_req == REQ_POST));
        d_dec     = r_d - D_W'(1);
    end

    // ram port control
    always_comb begin
        ram_we    = i_cmd.assign_wr && !refuse;
        ram_re    = 1'b0;
        ram_raddr = r_tgt;
        rd_occ_n  = r_rd_occ;
        if (i_cmd.rd_start) begin
            ram_re   = 1'b1;
            rd_occ_n = r_tgt_ok && r_occ[r_tgt];
        end else if (i_cmd.scan_step && (r_scan < SCAN_W'(NODES))) begin
            ram_re    = 1'b1;
            ram_raddr = r_scan[IDX_W-1:0];
            rd_occ_n  = r_occ[r_scan[IDX_W-1:0]];
        end else if (i_cmd.walk_rd) begin
            ram_re    = 1'b1;
            ram_raddr = r_cur;
            rd_occ_n  = r_occ[r_cur];
        end
    end

    atbt_ram #(
        .WIDTH (VAL_W),
        .DEPTH (NODES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (r_v),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rdata)
    );

    // occupancy bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_cmd.clear) begin
            r_occ <= '0;
        end else if (ram_we) begin
            r_occ[r_idx] <= (r_v != '0);
        end
    end

    // request registers and read tag
    always_ff @(posedge i_clk) begin
        r_rd_occ <= rd_occ_n;
        if (i_cmd.latch) begin
            r_req    <= i_req_type;
            r_idx    <= pos_idx;
            r_pos_ok <= pos_ok;
            r_v      <= i_item_value & VAL_MASK;
            r_tgt    <= (i_req_type == REQ_DEPTH) ? '0 : pos_idx;
            r_tgt_ok <= (i_req_type == REQ_DEPTH) ? 1'b1 : pos_ok;
            if (((i_req_type == REQ_ASSIGN) || (i_req_type == REQ_READ)) && !pos_ok) begin
                r_st <= ST_BADPOS;
            end else if ((i_req_type >= REQ_PARENT) && (i_req_type <= REQ_POST) &&
                         !r_occ[0]) begin
                r_st <= ST_EMPTY;
            end else begin
                r_st <= ST_OK;
            end
        end
        if (i_cmd.assign_wr) begin
            r_st <= refuse ? ST_REFUSED : ST_OK;
        end
        if (i_cmd.scan_hit) begin
            r_tgt    <= hit_t[IDX_W-1:0];
            r_tgt_ok <= (hit_t < TGT_W'(NODES));
        end
        if (i_cmd.scan_miss) begin
            r_tgt_ok <= 1'b0;
        end
    end

    // linear scan pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_v <= 1'b0;
        end else if (i_cmd.scan_init) begin
            r_chk_v <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_chk_v <= (r_scan < SCAN_W'(NODES));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_scan <= ((r_req == REQ_LCHILD) || (r_req == REQ_RCHILD)) ? '0 : SCAN_W'(1);
        end else if (i_cmd.scan_step && (r_scan < SCAN_W'(NODES))) begin
            r_scan    <= r_scan + SCAN_W'(1);
            r_chk_idx <= r_scan[IDX_W-1:0];
        end
    end

    // walk state and path stack
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d <= '0;
        end else if (i_cmd.walk_init) begin
            r_cur     <= '0;
            r_d       <= '0;
            r_phase   <= PH_DOWN;
            r_emitted <= 1'b0;
        end else if (i_cmd.walk_take) begin
            r_emitted <= 1'b1;
            r_pend_val <= eff;
        end else if (i_cmd.walk_adv) begin
            r_emitted <= 1'b0;
            case (r_phase)
                PH_DOWN: begin
                    if (can_left) begin
                        r_stack[r_d[SI_W-1:0]] <= r_cur;
                        r_d   <= r_d + D_W'(1);
                        r_cur <= wl_t[IDX_W-1:0];
                    end else begin
                        r_phase <= PH_LEFT;
                    end
                end
                PH_LEFT: begin
                    if (can_right) begin
                        r_stack[r_d[SI_W-1:0]] <= r_cur;
                        r_d     <= r_d + D_W'(1);
                        r_cur   <= wr_t[IDX_W-1:0];
                        r_phase <= PH_DOWN;
                    end else begin
                        r_phase <= PH_RIGHT;
                    end
                end
                default: begin
                    r_d     <= d_dec;
                    r_cur   <= r_stack[d_dec[SI_W-1:0]];
                    r_phase <= r_cur[0] ? PH_LEFT : PH_RIGHT;
                end
            endcase
        end
    end

    // one element held back so the final one can carry last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_has <= 1'b0;
        end else if (i_cmd.walk_init || (i_cmd.out_sel == OUT_LAST)) begin
            r_pend_has <= 1'b0;
        end else if (i_cmd.walk_take) begin
            r_pend_has <= 1'b1;
        end
    end

    // output register
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.out_sel != OUT_NONE) || (i_cmd.walk_take && r_pend_has)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_take && r_pend_has) begin
            r_out_val  <= r_pend_val;
            r_out_st   <= ST_OK;
            r_out_dep  <= depth;
            r_out_last <= 1'b0;
        end else begin
            case (i_cmd.out_sel)
                OUT_DIRECT: begin
                    r_out_val  <= '0;
                    r_out_st   <= r_st;
                    r_out_dep  <= depth;
                    r_out_last <= 1'b1;
                end
                OUT_RES: begin
                    r_out_val  <= eff;
                    r_out_st   <= r_st;
                    r_out_dep  <= depth;
                    r_out_last <= 1'b1;
                end
                OUT_LAST: begin
                    r_out_val  <= r_pend_val;
                    r_out_st   <= ST_OK;
                    r_out_dep  <= depth;
                    r_out_last <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // status to the sequencer
    always_comb begin
        o_sts.req       = r_req;
        o_sts.pos_ok    = r_pos_ok;
        o_sts.root_occ  = r_occ[0];
        o_sts.match     = match;
        o_sts.scan_done = !r_chk_v && (r_scan == SCAN_W'(NODES));
        o_sts.emit_now  = emit_now;
        o_sts.emitted   = r_emitted;
        o_sts.walk_end  = (r_phase == PH_RIGHT) && (r_d == '0);
        o_sts.pend_has  = r_pend_has;
        o_sts.out_free  = out_free;
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_val;
    assign o_status       = r_out_st;
    assign o_tree_depth   = r_out_dep;
    assign o_last         = r_out_last;

    `ASSERT_NEVER(a_stack_bound, i_clk, i_rst_n, r_d > D_W'(STACK_DEPTH))
    `ASSERT_PROP(a_last_has_elem, i_clk, i_rst_n, (i_cmd.out_sel == OUT_LAST) |-> r_pend_has)
    `ASSERT_PROP(a_hit_checked, i_clk, i_rst_n, i_cmd.scan_hit |-> r_chk_v)
    `ASSERT_PROP(a_clear_empties, i_clk, i_rst_n, i_cmd.clear |=> (r_occ == '0))
endmodule

// ===== hw/rtl/array_binary_tree_engine_top.sv =====
// top level of the array binary tree engine
// Binary tree of up to 63 values held in a single-port-write RAM, with a flip-flop
// occupancy bit per slot (cleared at reset and by the clear request, so no sweep is
// needed). One item is processed at a time; the result register lets the next item be
// taken while the last result waits. Relative searches scan the RAM one slot per cycle.
// Walks step through the tree one phase per cycle, plus a read for each visited node,
// and stall while a held-back element waits for a free output register.
module array_binary_tree_engine_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [atbt_pkg::REQ_W-1:0]   i_req_type,
    input  logic [atbt_pkg::LVL_W-1:0]   i_node_level,
    input  logic [atbt_pkg::ORD_W-1:0]   i_node_order,
    input  logic [atbt_pkg::VAL_W-1:0]   i_item_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [atbt_pkg::VAL_W-1:0]   o_result_value,
    output logic [atbt_pkg::ST_W-1:0]    o_status,
    output logic [atbt_pkg::DEP_W-1:0]   o_tree_depth,
    output logic                         o_last
);
    import atbt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer
    atbt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath
    atbt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_type     (i_req_type),
        .i_node_level   (i_node_level),
        .i_node_order   (i_node_order),
        .i_item_value   (i_item_value),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .o_tree_depth   (o_tree_depth),
        .o_last         (o_last)
    );
endmodule

// ===== verif/tb.sv =====
// testbench for the array binary tree engine: predictor, scoreboard and stimulus
`timescale 1ns / 1ps

import atbt_pkg::*;

typedef struct {
    logic [VAL_W-1:0] value;
    logic [ST_W-1:0]  st;
    logic [DEP_W-1:0] depth;
    logic             last;
} t_tree_result;

class tree_scoreboard;
    logic [VAL_W-1:0] nodes [NODES];
    int               path [STACK_DEPTH];
    t_tree_result     pending [$];
    int               mismatches;
    int               results_seen;

    function new();
        mismatches   = 0;
        results_seen = 0;
        foreach (nodes[i]) nodes[i] = '0;
    endfunction

    function logic [VAL_W-1:0] peek(int i);
        return (i < NODES) ? nodes[i] : '0;
    endfunction

    function logic [DEP_W-1:0] levels_used();
        int n, d;
        n = 0;
        d = 0;
        for (int i = 0; i < NODES; i++) if (nodes[i] != 0) n = i + 1;
        while (n != 0) begin
            d++;
            n = n >> 1;
        end
        return DEP_W'(d);
    endfunction

    function void push(logic [VAL_W-1:0] v, logic [ST_W-1:0] s, logic l);
        t_tree_result r;
        r.value = v;
        r.st    = s;
        r.depth = levels_used();
        r.last  = l;
        pending.push_back(r);
    endfunction

    // walk the tree keeping the path in a small stack, emit per visit
    function void walk_order(logic [REQ_W-1:0] kind);
        int cur, d, ph, child, first;
        cur   = 0;
        d     = 0;
        ph    = 0;
        first = pending.size();
        forever begin
            if (ph == 0) begin
                if (kind == REQ_PRE) push(nodes[cur], ST_OK, 1'b0);
                if (peek(2 * cur + 1) != 0 && d < STACK_DEPTH) begin
                    path[d] = cur;
                    d++;
                    cur = 2 * cur + 1;
                    continue;
                end
                ph = 1;
            end
            if (ph == 1) begin
                if (kind == REQ_IN) push(nodes[cur], ST_OK, 1'b0);
                if (peek(2 * cur + 2) != 0 && d < STACK_DEPTH) begin
                    path[d] = cur;
                    d++;
                    cur = 2 * cur + 2;
                    ph  = 0;
                    continue;
                end
                ph = 2;
            end
            if (kind == REQ_POST) push(nodes[cur], ST_OK, 1'b0);
            if (d == 0) break;
            child = cur;
            d--;
            cur = path[d];
            ph  = (child == 2 * cur + 1) ? 1 : 2;
        end
        if (pending.size() > first) pending[pending.size() - 1].last = 1'b1;
    endfunction

    // note one accepted request and predict its results
    function void note_request(logic [REQ_W-1:0] req, logic [LVL_W-1:0] lvl,
                               logic [ORD_W-1:0] ord, logic [VAL_W-1:0] val);
        int base, idx, start;
        bit ok, refuse;
        logic [VAL_W-1:0] v, res;
        v   = val & VAL_MASK;
        idx = 0;
        ok  = 0;
        if (lvl >= 1 && lvl <= LEVELS) begin
            base = 1 << (lvl - 1);
            if (ord >= 1 && ord <= base) begin
                idx = base + ord - 2;
                ok  = idx < NODES;
            end
        end
        if (req == REQ_CLEAR) begin
            foreach (nodes[i]) nodes[i] = '0;
            push('0, ST_OK, 1'b1);
        end else if (req == REQ_ASSIGN || req == REQ_READ) begin
            if (!ok) push('0, ST_BADPOS, 1'b1);
            else if (req == REQ_READ) push(nodes[idx], ST_OK, 1'b1);
            else begin
                refuse = 0;
                if (v != 0 && idx != 0 && peek((idx + 1) / 2 - 1) == 0) refuse = 1;
                else if (v == 0 && (peek(2 * idx + 1) != 0 || peek(2 * idx + 2) != 0))
                    refuse = 1;
                if (!refuse) nodes[idx] = v;
                push(nodes[idx], refuse ? ST_REFUSED : ST_OK, 1'b1);
            end
        end else if (req > REQ_POST) begin
            push('0, ST_OK, 1'b1);
        end else if (nodes[0] == 0) begin
            push('0, ST_EMPTY, 1'b1);
        end else if (req >= REQ_PRE) begin
            walk_order(req);
        end else if (req == REQ_DEPTH) begin
            push(nodes[0], ST_OK, 1'b1);
        end else begin
            res   = '0;
            start = (req == REQ_LCHILD || req == REQ_RCHILD) ? 0 : 1;
            for (int i = start; i < NODES; i++) begin
                if (nodes[i] != v) continue;
                if (req == REQ_PARENT) begin res = peek((i + 1) / 2 - 1); break; end
                if (req == REQ_LCHILD) begin res = peek(2 * i + 1); break; end
                if (req == REQ_RCHILD) begin res = peek(2 * i + 2); break; end
                if (req == REQ_LSIB && i % 2 == 0) begin res = peek(i - 1); break; end
                if (req == REQ_RSIB && i % 2 == 1) begin res = peek(i + 1); break; end
            end
            push(res, ST_OK, 1'b1);
        end
    endfunction

    // compare one result item against the oldest prediction
    function void check_result(logic [VAL_W-1:0] v, logic [ST_W-1:0] s,
                               logic [DEP_W-1:0] d, logic l);
        t_tree_result e;
        results_seen++;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item value=%0d", v);
            return;
        end
        e = pending.pop_front();
        if (e.value !== v || e.st !== s || e.depth !== d || e.last !== l) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp val=%0d st=%0d dep=%0d last=%0b, got %0d %0d %0d %0b",
                         e.value, e.st, e.depth, e.last, v, s, d, l);
        end
    endfunction
endclass

module tb;
    localparam int WATCHDOG = 20000;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    logic [REQ_W-1:0] i_req_type;
    logic [LVL_W-1:0] i_node_level;
    logic [ORD_W-1:0] i_node_order;
    logic [VAL_W-1:0] i_item_value;
    logic             o_out_valid;
    logic             i_out_ready;
    logic [VAL_W-1:0] o_result_value;
    logic [ST_W-1:0]  o_status;
    logic [DEP_W-1:0] o_tree_depth;
    logic             o_last;

    tree_scoreboard board;
    int send_idle_pct;
    int recv_idle_pct;
    int requests_sent;
    int quiet_cycles;

    array_binary_tree_engine_top dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver side: random stall and result checking
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_result(o_result_value, o_status, o_tree_depth, o_last);
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("watchdog expired");
            $display("Verification failed");
            $finish;
        end
    end

    // send one request item, with a random gap first; valid stays up until the next
    // gap or drain so back to back items need only one drive per edge
    task automatic send_request(logic [REQ_W-1:0] req, logic [LVL_W-1:0] lvl,
                                logic [ORD_W-1:0] ord, logic [VAL_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_node_level <= lvl;
        i_node_order <= ord;
        i_item_value <= val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_request(req, lvl, ord, val);
        requests_sent++;
    endtask

    // pick a random slot position, mostly valid
    task automatic rand_pos(output logic [LVL_W-1:0] lvl, output logic [ORD_W-1:0] ord);
        if ($urandom_range(9) == 0) begin
            lvl = LVL_W'($urandom);
            ord = ORD_W'($urandom);
        end else begin
            lvl = LVL_W'($urandom_range(LEVELS, 1));
            ord = ORD_W'($urandom_range(1 << (lvl - 1), 1));
        end
    endtask

    // grow a tree top down with small random values
    task automatic build_tree(int count);
        logic [LVL_W-1:0] l;
        logic [ORD_W-1:0] o;
        send_request(REQ_ASSIGN, 3'd1, 6'd1, VAL_W'($urandom_range(20, 1)));
        for (int k = 0; k < count; k++) begin
            l = LVL_W'($urandom_range(LEVELS, 2));
            o = ORD_W'($urandom_range(1 << (l - 1), 1));
            send_request(REQ_ASSIGN, l, o, VAL_W'($urandom_range(20, 1)));
        end
    endtask

    task automatic random_phase(int n);
        logic [LVL_W-1:0] l;
        logic [ORD_W-1:0] o;
        logic [REQ_W-1:0] r;
        int pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            rand_pos(l, o);
            if (pick < 3) r = REQ_CLEAR;
            else if (pick < 40) r = REQ_ASSIGN;
            else if (pick < 45) r = REQ_W'(12 + $urandom_range(3));
            else r = REQ_W'($urandom_range(REQ_POST, REQ_READ));
            if (pick < 2)
                send_request(r, LVL_W'($urandom), ORD_W'($urandom), VAL_W'($urandom));
            else if ($urandom_range(7) == 0)
                send_request(r, l, o, ($urandom_range(3) == 0) ? 16'd0 : VAL_W'($urandom));
            else send_request(r, l, o, VAL_W'($urandom_range(20)));
            if (r == REQ_CLEAR) build_tree($urandom_range(12, 4));
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    initial begin
        board         = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        requests_sent = 0;
        quiet_cycles  = 0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_out_ready   = 1'b0;
        i_req_type    = '0;
        i_node_level  = '0;
        i_node_order  = '0;
        i_item_value  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty tree, bad positions, refusals, extremes, walks
        send_request(REQ_DEPTH, 3'd1, 6'd1, 16'd0);
        send_request(REQ_PRE, 3'd1, 6'd1, 16'd0);
        send_request(REQ_ASSIGN, 3'd0, 6'd1, 16'd5);
        send_request(REQ_READ, 3'd7, 6'd1, 16'd0);
        send_request(REQ_READ, 3'd2, 6'd0, 16'd0);
        send_request(REQ_READ, 3'd3, 6'd63, 16'd0);
        send_request(REQ_ASSIGN, 3'd2, 6'd1, 16'd9);
        send_request(REQ_ASSIGN, 3'd1, 6'd1, 16'hFFFF);
        send_request(REQ_ASSIGN, 3'd2, 6'd1, 16'd1);
        send_request(REQ_ASSIGN, 3'd2, 6'd2, 16'd2);
        send_request(REQ_ASSIGN, 3'd1, 6'd1, 16'd0);
        send_request(REQ_ASSIGN, 3'd6, 6'd32, 16'd3);
        send_request(REQ_PARENT, 3'd1, 6'd1, 16'd2);
        send_request(REQ_LCHILD, 3'd1, 6'd1, 16'hFFFF);
        send_request(REQ_RCHILD, 3'd1, 6'd1, 16'hFFFF);
        send_request(REQ_LSIB, 3'd1, 6'd1, 16'd2);
        send_request(REQ_RSIB, 3'd1, 6'd1, 16'd1);
        send_request(REQ_PARENT, 3'd1, 6'd1, 16'd0);
        send_request(REQ_DEPTH, 3'd1, 6'd1, 16'd0);
        send_request(REQ_PRE, 3'd1, 6'd1, 16'd0);
        send_request(REQ_IN, 3'd1, 6'd1, 16'd0);
        send_request(REQ_POST, 3'd1, 6'd1, 16'd0);
        send_request(4'd15, 3'd7, 6'd63, 16'hFFFF);
        send_request(REQ_CLEAR, 3'd1, 6'd1, 16'd0);
        drain();

        // random phases under three idling profiles
        send_idle_pct = 19;
        recv_idle_pct = 71;
        build_tree(10);
        random_phase(40);
        drain();
        send_idle_pct = 71;
        recv_idle_pct = 19;
        random_phase(50);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(50);
        drain();

        $display("sent %0d requests, checked %0d result items, %0d mismatches",
                 requests_sent, board.results_seen, board.mismatches);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== array_binary_tree_engine_top.f =====
+incdir+hw/rtl
hw/rtl/atbt_pkg.sv
hw/rtl/atbt_ram.sv
hw/rtl/atbt_ctrl.sv
hw/rtl/atbt_dp.sv
hw/rtl/array_binary_tree_engine_top.sv
verif/tb.sv
